>>> src/jpl_pkg.sv
// Shared types, codes and constants for the joypad port with light gun.
package jpl_pkg;

    typedef enum logic [1:0] {
        OP_STROBE    = 2'd0,
        OP_READ0     = 2'd1,
        OP_READ1     = 2'd2,
        OP_FRAME_END = 2'd3
    } jpl_op_t;

    typedef enum logic [1:0] {
        CFG_GUN_ENABLED     = 2'd0,
        CFG_LIGHT_THRESHOLD = 2'd1,
        CFG_STALL_LIMIT     = 2'd2,
        CFG_MIN_POLL_READS  = 2'd3
    } jpl_cfg_idx_t;

    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  LIGHT_THRESHOLD_RST = 8'd150;
    localparam logic [7:0]  STALL_LIMIT_RST     = 8'd180;
    localparam logic [15:0] MIN_POLL_READS_RST  = 16'd256;

    localparam logic [7:0]  OPEN_BUS_MASK = 8'hE0;
    localparam int          NO_LIGHT_POS  = 3;
    localparam int          TRIGGER_POS   = 4;
    localparam logic [15:0] POLL_READS_MAX = 16'hFFFF;

    typedef struct packed {
        jpl_op_t     op;
        logic        strobe_bit;
        logic [7:0]  open_bus;
        logic [7:0]  pad0_buttons;
        logic [7:0]  pad1_buttons;
        logic [15:0] insn_addr;
        logic        aim_valid;
        logic [23:0] pixel_rgb;
        logic        trigger_pressed;
        logic        rendering_enabled;
        logic        screen_black;
    } jpl_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       light_sensed;
        logic       stall_flag;
    } jpl_out_t;

    typedef struct packed {
        logic        gun_enabled;
        logic [7:0]  light_threshold;
        logic [7:0]  stall_frame_limit;
        logic [15:0] min_poll_reads;
    } jpl_cfg_t;

    // Gun status after the current beat.
    typedef struct packed {
        logic light;
        logic stalled;
    } jpl_gun_status_t;

endpackage

>>> src/jpl_if.sv
// Valid/ready channel interfaces for request and result beats.
interface jpl_in_if;
    import jpl_pkg::*;
    logic    valid;
    logic    ready;
    jpl_in_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface jpl_out_if;
    import jpl_pkg::*;
    logic     valid;
    logic     ready;
    jpl_out_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> src/jpl_shift.sv
// Strobe latch and the two serial button shift registers.
module jpl_shift (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  jpl_pkg::jpl_in_t item,
    output logic           port_bit
);
    import jpl_pkg::*;

    logic       strobe_reg, strobe_next;
    logic [7:0] shift0_reg, shift0_next;
    logic [7:0] shift1_reg, shift1_next;

    always_comb
    begin
        strobe_next = strobe_reg;
        shift0_next = shift0_reg;
        shift1_next = shift1_reg;
        port_bit    = 1'b0;
        unique case (item.op)
            OP_STROBE:
            begin
                strobe_next = item.strobe_bit;
                if (strobe_reg || item.strobe_bit)
                begin
                    shift0_next = item.pad0_buttons;
                    shift1_next = item.pad1_buttons;
                end
            end
            OP_READ0:
            begin
                if (strobe_reg)
                    port_bit = item.pad0_buttons[0];
                else
                begin
                    port_bit    = shift0_reg[0];
                    shift0_next = {1'b1, shift0_reg[7:1]};
                end
            end
            OP_READ1:
            begin
                if (strobe_reg)
                    port_bit = item.pad1_buttons[0];
                else
                begin
                    port_bit    = shift1_reg[0];
                    shift1_next = {1'b1, shift1_reg[7:1]};
                end
            end
            OP_FRAME_END:
            begin
                port_bit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            shift0_reg <= '0;
            shift1_reg <= '0;
        end
        else if (fire)
        begin
            strobe_reg <= strobe_next;
            shift0_reg <= shift0_next;
            shift1_reg <= shift1_next;
        end
    end

endmodule

>>> src/jpl_gun.sv
// Light sampling, poll watchdog and end-of-frame stall check.
module jpl_gun (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  jpl_pkg::jpl_in_t        item,
    input  jpl_pkg::jpl_cfg_t       cfg,
    output jpl_pkg::jpl_gun_status_t status
);
    import jpl_pkg::*;

    logic        light_reg, light_next;
    logic [15:0] reads_reg, reads_next;
    logic [15:0] addr_reg, addr_next;
    logic        mixed_reg, mixed_next;
    logic [7:0]  frames_reg, frames_next;
    logic        stalled_reg, stalled_next;

    logic lit;
    logic suspect;

    assign lit = item.aim_valid
                 && (item.pixel_rgb[23:16] > cfg.light_threshold)
                 && (item.pixel_rgb[15:8]  > cfg.light_threshold)
                 && (item.pixel_rgb[7:0]   > cfg.light_threshold);

    assign suspect = cfg.gun_enabled && !item.trigger_pressed && !light_reg
                     && !item.rendering_enabled && (reads_reg >= cfg.min_poll_reads)
                     && !mixed_reg && item.screen_black;

    always_comb
    begin
        light_next   = light_reg;
        reads_next   = reads_reg;
        addr_next    = addr_reg;
        mixed_next   = mixed_reg;
        frames_next  = frames_reg;
        stalled_next = stalled_reg;
        if (item.op == OP_READ1 && cfg.gun_enabled)
        begin
            light_next = lit;
            if (reads_reg == '0)
            begin
                // First read of a frame: a new polling address breaks the streak.
                if (frames_reg != '0 && addr_reg != item.insn_addr)
                    frames_next = '0;
                addr_next = item.insn_addr;
            end
            else if (addr_reg != item.insn_addr)
                mixed_next = 1'b1;
            if (reads_reg != POLL_READS_MAX)
                reads_next = reads_reg + 16'd1;
        end
        else if (item.op == OP_FRAME_END)
        begin
            if (!suspect)
                frames_next = '0;
            else if (frames_reg < cfg.stall_frame_limit)
                frames_next = frames_reg + 8'd1;
            stalled_next = (frames_next >= cfg.stall_frame_limit);
            reads_next   = '0;
            mixed_next   = 1'b0;
        end
    end

    assign status.light   = light_next;
    assign status.stalled = stalled_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg   <= 1'b0;
            reads_reg   <= '0;
            addr_reg    <= '0;
            mixed_reg   <= 1'b0;
            frames_reg  <= '0;
            stalled_reg <= 1'b0;
        end
        else if (fire)
        begin
            light_reg   <= light_next;
            reads_reg   <= reads_next;
            addr_reg    <= addr_next;
            mixed_reg   <= mixed_next;
            frames_reg  <= frames_next;
            stalled_reg <= stalled_next;
        end
    end

endmodule

>>> src/joypad_port_with_light_gun_unit.sv
// Top level of the joypad port with light gun: input register, logic, result register.
//
//  channel | direction | beat contents
//  --------+-----------+----------------------------------------------------------
//  req     | sink      | op, strobe_bit, open_bus, pads, pc, aim, pixel, trigger, ...
//  rsp     | source    | read_data, light_sensed, stall_flag
//  cfg     | write     | cfg_we, cfg_index, cfg_data (16 bits, no read-back)
//
// Each request beat yields exactly one result beat. The beat is held in the input
// register, then its result is loaded into the result register and offered on rsp;
// the move waits while the result register holds an untaken beat. A new beat is
// accepted every cycle while the result side keeps taking beats. All state
// (strobe, shift registers, watchdog) is updated when a beat leaves the input
// register, so one short pass of logic sets the rate. When rsp stalls, the
// result register holds and the input register fills, then req.ready drops.
// Reset clears all control state and loads the register defaults.
module joypad_port_with_light_gun_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    jpl_in_if.sink                          req,
    jpl_out_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [jpl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jpl_pkg::*;

    jpl_cfg_t        cfg_reg;
    jpl_in_t         item_reg;
    logic            item_valid_reg;
    jpl_out_t        res_reg, res_next;
    logic            res_valid_reg;
    logic            advance;
    logic            port_bit;
    jpl_gun_status_t gun_status;

    // Move the held beat on when the result register is empty or draining.
    assign advance   = item_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    // Configuration registers; the user must write them only while the unit is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gun_enabled       <= 1'b0;
            cfg_reg.light_threshold   <= LIGHT_THRESHOLD_RST;
            cfg_reg.stall_frame_limit <= STALL_LIMIT_RST;
            cfg_reg.min_poll_reads    <= MIN_POLL_READS_RST;
        end
        else if (cfg_we)
        begin
            unique case (jpl_cfg_idx_t'(cfg_index))
                CFG_GUN_ENABLED:     cfg_reg.gun_enabled       <= cfg_data[0];
                CFG_LIGHT_THRESHOLD: cfg_reg.light_threshold   <= cfg_data[7:0];
                CFG_STALL_LIMIT:     cfg_reg.stall_frame_limit <= cfg_data[7:0];
                CFG_MIN_POLL_READS:  cfg_reg.min_poll_reads    <= cfg_data[15:0];
            endcase
        end
    end

    // Input register: capture the accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (req.ready)
            item_valid_reg <= req.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else if (req.valid && req.ready)
            item_reg <= req.item;
    end

    jpl_shift u_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (item_reg),
        .port_bit (port_bit)
    );

    jpl_gun u_gun (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .status (gun_status)
    );

    // Assemble the result byte; strobe writes and frame ends return zero.
    always_comb
    begin
        res_next.read_data    = '0;
        res_next.light_sensed = gun_status.light;
        res_next.stall_flag   = gun_status.stalled;
        if (item_reg.op == OP_READ0 || item_reg.op == OP_READ1)
        begin
            res_next.read_data    = item_reg.open_bus & OPEN_BUS_MASK;
            res_next.read_data[0] = port_bit;
            if (item_reg.op == OP_READ1 && cfg_reg.gun_enabled)
            begin
                res_next.read_data[NO_LIGHT_POS] = !gun_status.light;
                res_next.read_data[TRIGGER_POS]  = item_reg.trigger_pressed;
            end
        end
    end

    // Result register: hold until rsp takes the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (rsp.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.item  = res_reg;

endmodule
